@@ hdl/etm_pkg.sv @@
// ----------------------------------------------------------------------------
// etm_pkg
// Shared types, constants and the integer log2 table for the tone mapper.
// ----------------------------------------------------------------------------
package etm_pkg;

  localparam int SUM_W    = 32;
  localparam int SCALE_W  = 32;
  localparam int GAMMA_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 64;
  localparam int LOG_FRAC = 56;
  localparam int MANT_W   = 63;
  localparam int EXP_W    = 6;
  localparam int LOG_W    = 64;
  localparam int DIFF_W   = 62;
  localparam int PART_W   = 47;
  localparam int WIDE_W   = 78;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_CH   = 3;

  // normalize stage, then two stages per fraction bit
  localparam int LOG_STG  = 1 + 2 * LOG_FRAC;
  // partial products, difference, eight search steps
  localparam int SRCH_STG = 2 + BYTE_W;
  // product stage ahead of both units
  localparam int PIPE_STG = 1 + LOG_STG + SRCH_STG;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 8'd0,
    CFG_GAMMA = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                zero;
    logic                big;
    logic [EXP_W-1:0]    expo;
    logic [LOG_FRAC-1:0] frac;
  } log_tag_t;

  typedef struct packed {
    logic zero;
    logic big;
    logic neg;
  } srch_tag_t;

  typedef logic [LOG_W-1:0] log_tbl_t [256];

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t       t;
    logic [63:0]    m;
    logic [63:0]    r;
    logic [127:0]   sq;
    logic [LOG_FRAC-1:0] frac;
    int             e;
    t[0] = '0;
    for (int n = 1; n < 256; n++) begin
      e = 0;
      for (int b = 0; b < 8; b++) begin
        if (((n >> b) & 1) == 1) e = b;
      end
      m = 64'(n) << (62 - e);
      frac = '0;
      for (int i = LOG_FRAC - 1; i >= 0; i--) begin
        sq = {64'd0, m} * {64'd0, m};
        r = sq[125:62];
        if (r[63]) begin
          frac[i] = 1'b1;
          r = r >> 1;
        end
        m = r;
      end
      t[n] = (64'(e) << LOG_FRAC) | 64'(frac);
    end
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();

endpackage

@@ hdl/etm_if.sv @@
// ----------------------------------------------------------------------------
// etm_if
// Request channels of the tone mapper: pixel in, bytes out, register write.
// ----------------------------------------------------------------------------
interface etm_in_if;
  logic                       valid;
  logic                       ready;
  logic [etm_pkg::SUM_W-1:0]  red_sum;
  logic [etm_pkg::SUM_W-1:0]  green_sum;
  logic [etm_pkg::SUM_W-1:0]  blue_sum;
  modport source (output valid, red_sum, green_sum, blue_sum, input ready);
  modport sink   (input valid, red_sum, green_sum, blue_sum, output ready);
endinterface

interface etm_out_if;
  logic                       valid;
  logic                       ready;
  logic [etm_pkg::BYTE_W-1:0] blue_byte;
  logic [etm_pkg::BYTE_W-1:0] green_byte;
  logic [etm_pkg::BYTE_W-1:0] red_byte;
  modport source (output valid, blue_byte, green_byte, red_byte, input ready);
  modport sink   (input valid, blue_byte, green_byte, red_byte, output ready);
endinterface

interface etm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [etm_pkg::CFG_IDX_W-1:0] index;
  logic [etm_pkg::SCALE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/etm_log.sv @@
// ----------------------------------------------------------------------------
// etm_log
// Pipelined base-2 log of the product's low 40 bits, one fraction bit per two stages.
// ----------------------------------------------------------------------------
module etm_log (
  input  logic                          clk,
  input  logic [etm_pkg::LOG_STG-1:0]   ld,
  input  logic [etm_pkg::PROD_W-1:0]    prod,
  output etm_pkg::log_tag_t             tag_o
);

  localparam int NB = etm_pkg::LOG_FRAC;

  logic [etm_pkg::MANT_W-1:0] m_r   [NB];
  etm_pkg::log_tag_t          tag_r [etm_pkg::LOG_STG];
  logic [63:0]                p00_r [NB];
  logic [62:0]                p01_r [NB];
  logic [61:0]                p11_r [NB];

  logic [etm_pkg::EXP_W-1:0]  expo;
  logic [etm_pkg::MANT_W-1:0] norm;

  always_comb begin
    expo = '0;
    for (int b = 0; b < 40; b++) begin
      if (prod[b]) expo = etm_pkg::EXP_W'(b);
    end
    norm = etm_pkg::MANT_W'(prod[39:0]) << (6'd62 - expo);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m_r[0]          <= norm;
      tag_r[0].zero   <= (prod == '0);
      tag_r[0].big    <= |prod[etm_pkg::PROD_W-1:40];
      tag_r[0].expo   <= expo;
      tag_r[0].frac   <= '0;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bit
    logic [125:0]      sq;
    logic [63:0]       r;
    logic [62:0]       m_nxt;
    etm_pkg::log_tag_t tag_nxt;

    assign sq    = {p11_r[j], 64'd0} + {30'd0, p01_r[j], 33'd0} + {62'd0, p00_r[j]};
    assign r     = sq[125:62];
    assign m_nxt = r[63] ? r[63:1] : r[62:0];

    always_comb begin
      tag_nxt              = tag_r[2*j+1];
      tag_nxt.frac[NB-1-j] = r[63];
    end

    always_ff @(posedge clk) begin
      if (ld[2*j+1]) begin
        p00_r[j]       <= 64'(m_r[j][31:0]) * 64'(m_r[j][31:0]);
        p01_r[j]       <= 63'(m_r[j][31:0]) * 63'(m_r[j][62:32]);
        p11_r[j]       <= 62'(m_r[j][62:32]) * 62'(m_r[j][62:32]);
        tag_r[2*j+1]   <= tag_r[2*j];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[2*j+2]) begin
        tag_r[2*j+2] <= tag_nxt;
      end
    end

    if (j < NB - 1) begin : g_m
      always_ff @(posedge clk) begin
        if (ld[2*j+2]) m_r[j+1] <= m_nxt;
      end
    end else begin : g_last
      logic unused_m;
      assign unused_m = ^m_nxt;
    end
  end

  assign tag_o = tag_r[etm_pkg::LOG_STG-1];

endmodule

@@ hdl/etm_search.sv @@
// ----------------------------------------------------------------------------
// etm_search
// Scales the log by the exponent and searches the byte table for the floor.
// ----------------------------------------------------------------------------
module etm_search (
  input  logic                           clk,
  input  logic [etm_pkg::SRCH_STG-1:0]   ld,
  input  logic [etm_pkg::GAMMA_W-1:0]    gamma,
  input  etm_pkg::log_tag_t              tag_i,
  output logic [etm_pkg::BYTE_W-1:0]     byte_o
);

  localparam int NS = etm_pkg::BYTE_W;

  logic [etm_pkg::DIFF_W-1:0] diff;
  logic [etm_pkg::PART_W-1:0] plo_r;
  logic [etm_pkg::PART_W-1:0] phi_r;
  logic                       zero_r;
  logic                       big_r;
  logic [etm_pkg::WIDE_W-1:0] pw;
  logic [etm_pkg::WIDE_W-1:0] cw;
  logic [etm_pkg::WIDE_W-1:0] vw;

  etm_pkg::srch_tag_t         tag_r [NS+1];
  logic [etm_pkg::LOG_W-1:0]  w_r   [NS+1];
  logic [NS-1:0]              r_r   [NS+1];

  assign diff = {6'(6'd40 - tag_i.expo), 56'd0} - {6'd0, tag_i.frac};

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      plo_r  <= etm_pkg::PART_W'(gamma) * etm_pkg::PART_W'(diff[30:0]);
      phi_r  <= etm_pkg::PART_W'(gamma) * etm_pkg::PART_W'(diff[61:31]);
      zero_r <= tag_i.zero;
      big_r  <= tag_i.big;
    end
  end

  assign pw = {phi_r, 31'd0} + etm_pkg::WIDE_W'(plo_r);
  assign cw = etm_pkg::WIDE_W'({etm_pkg::LOG_TBL[255], 12'd0});
  assign vw = cw - pw;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      tag_r[0].zero <= zero_r;
      tag_r[0].big  <= big_r;
      tag_r[0].neg  <= (pw > cw);
      w_r[0]        <= vw[75:12];
      r_r[0]        <= '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [NS-1:0] cand;
    logic          take;

    assign cand = r_r[s] | (NS'(1) << (NS - 1 - s));
    assign take = !tag_r[s].neg && (cand != '1) &&
                  (etm_pkg::LOG_TBL[cand] <= w_r[s]);

    always_ff @(posedge clk) begin
      if (ld[s+2]) begin
        tag_r[s+1] <= tag_r[s];
        w_r[s+1]   <= w_r[s];
        r_r[s+1]   <= take ? cand : r_r[s];
      end
    end
  end

  logic unused_w;
  assign unused_w = ^w_r[NS];

  assign byte_o = tag_r[NS].zero ? '0 :
                  tag_r[NS].big  ? '1 : r_r[NS];

endmodule

@@ hdl/exposure_gamma_tone_map.sv @@
// ----------------------------------------------------------------------------
// exposure_gamma_tone_map
// Exposure scale and inverse-gamma power of three channel sums to bytes.
//
//   channel  dir  payload                                 request when
//   in_ch    in   red_sum, green_sum, blue_sum (32 each)  valid & ready
//   out_ch   out  blue_byte, green_byte, red_byte (8)     valid & ready
//   cfg_ch   in   index (8), data (32)                    valid & ready
//
// One pixel per clock unless the output stalls. Stages: product, 113 log stages
// (two per fraction bit of the 56-bit log), 10 scale and search stages.
// Reset clears valid bits and loads scale 1.0 and exponent 1862.
// Each stage holds only when full and the next one holds; bubbles close up,
// so requests keep entering while a finished pixel waits at the output, until every stage is full.
// ----------------------------------------------------------------------------
module exposure_gamma_tone_map (
  input  logic       clk,
  input  logic       rst_n,
  etm_in_if.sink     in_ch,
  etm_out_if.source  out_ch,
  etm_cfg_if.sink    cfg_ch
);

  localparam int N  = etm_pkg::PIPE_STG;
  localparam int LS = etm_pkg::LOG_STG;

  logic [etm_pkg::SCALE_W-1:0] scale_r;
  logic [etm_pkg::GAMMA_W-1:0] gamma_r;
  logic [N-1:0]                v_r;
  logic [N:0]                  ld;
  logic [etm_pkg::PROD_W-1:0]  prod_r [etm_pkg::NUM_CH];
  logic [etm_pkg::SUM_W-1:0]   sums   [etm_pkg::NUM_CH];
  logic [etm_pkg::BYTE_W-1:0]  bytes  [etm_pkg::NUM_CH];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'd16777216;
      gamma_r <= 16'd1862;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == etm_pkg::CFG_SCALE) scale_r <= cfg_ch.data;
      if (cfg_ch.index == etm_pkg::CFG_GAMMA) gamma_r <= cfg_ch.data[15:0];
    end
  end

  always_comb begin
    ld[N] = out_ch.ready;
    for (int k = N - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < N; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = ld[0];

  assign sums[0] = in_ch.blue_sum;
  assign sums[1] = in_ch.green_sum;
  assign sums[2] = in_ch.red_sum;

  for (genvar c = 0; c < etm_pkg::NUM_CH; c++) begin : g_ch
    etm_pkg::log_tag_t ltag;

    always_ff @(posedge clk) begin
      if (ld[0]) prod_r[c] <= etm_pkg::PROD_W'(sums[c]) * etm_pkg::PROD_W'(scale_r);
    end

    etm_log u_log (
      .clk   (clk),
      .ld    (ld[LS:1]),
      .prod  (prod_r[c]),
      .tag_o (ltag)
    );

    etm_search u_search (
      .clk    (clk),
      .ld     (ld[N-1:LS+1]),
      .gamma  (gamma_r),
      .tag_i  (ltag),
      .byte_o (bytes[c])
    );
  end

  assign out_ch.valid      = v_r[N-1];
  assign out_ch.blue_byte  = bytes[0];
  assign out_ch.green_byte = bytes[1];
  assign out_ch.red_byte   = bytes[2];

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output drains");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipe");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("pending result dropped");

endmodule
